@@ hdl/bss_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded stack with search: shared package
// Field widths, operation and status codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int DEPTH_DEF   = 256;
  localparam int WORD_W      = 32;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int CAP_W       = 9;
  localparam int DIST_W      = 8;
  localparam int COUNT_W     = 9;
  localparam int OUT_TDATA_W = 56;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Operation carried by an input beat.
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_t;

  // Outcome reported with every result beat.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SRCH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    push;
    logic    pop;
    logic    srch_start;
    logic    srch_step;
    logic    out_load;
    logic    out_sel_pop;
    logic    out_sel_dist;
    status_t out_status;
  } ctl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ hdl/bss_dp.sv @@
// ----------------------------------------------------------------------------
// Bounded stack with search: datapath
// Word memory, fill count, capacity register, search scan counter and the
// output beat register.
// ----------------------------------------------------------------------------
module bss_dp #(
  parameter int DEPTH = bss_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [bss_pkg::CAP_W-1:0]       cfg_wr_data,
  input  logic [bss_pkg::WORD_W-1:0]      in_word,
  input  bss_pkg::ctl_cmd_t               cmd,
  output bss_pkg::dp_status_t             status,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [bss_pkg::STATUS_W-1:0]    out_status,
  output logic [bss_pkg::WORD_W-1:0]      out_popped,
  output logic [bss_pkg::DIST_W-1:0]      out_distance,
  output logic [bss_pkg::COUNT_W-1:0]     out_count,
  output logic                            out_is_empty,
  output logic                            out_is_full
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = (CNT_W > bss_pkg::CAP_W) ? CNT_W : bss_pkg::CAP_W;

  logic [bss_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bss_pkg::WORD_W-1:0] rdata_r;
  logic [bss_pkg::WORD_W-1:0] key_r;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [bss_pkg::CAP_W-1:0]  capacity_r;
  logic [ADDR_W-1:0]          scan_d_r;
  logic [ADDR_W-1:0]          rd_addr;
  logic [CNT_W-1:0]           rd_pos;
  logic [CMP_W-1:0]           cap_ext, eff_cap;
  logic [CNT_W+bss_pkg::COUNT_W-1:0] cnt_wide;
  logic [ADDR_W+bss_pkg::DIST_W-1:0] dist_wide;

  logic                       out_valid_r;
  logic [bss_pkg::STATUS_W-1:0] out_status_r;
  logic [bss_pkg::WORD_W-1:0] out_popped_r;
  logic [bss_pkg::DIST_W-1:0] out_distance_r;
  logic [bss_pkg::COUNT_W-1:0] out_count_r;
  logic                       out_is_empty_r;
  logic                       out_is_full_r;

  // Effective capacity is the configured value clipped to the memory depth.
  always_comb begin
    cap_ext = CMP_W'(capacity_r);
    eff_cap = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
  end

  // Fill count after the operation being committed this cycle.
  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Read address: the top word, or the next word down during a scan.
  always_comb begin
    if (cmd.srch_step) begin
      rd_pos = count_r - CNT_W'(2) - CNT_W'(scan_d_r);
    end else begin
      rd_pos = count_r - CNT_W'(1);
    end
    rd_addr = rd_pos[ADDR_W-1:0];
  end

  // Status toward the controller.
  always_comb begin
    status.full      = (CMP_W'(count_r) >= eff_cap);
    status.empty     = (count_r == '0);
    status.hit       = (rdata_r == key_r);
    status.scan_last = (CNT_W'(scan_d_r) == (count_r - CNT_W'(1)));
    status.out_free  = !out_valid_r || out_tready;
  end

  // Word memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count_r[ADDR_W-1:0]] <= in_word;
    end
    rdata_r <= mem[rd_addr];
  end

  // Fill count and capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      capacity_r <= bss_pkg::CAP_RESET;
    end else begin
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
      end
    end
  end

  // Search key and scan distance.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r <= in_word;
    end
    if (cmd.srch_start) begin
      scan_d_r <= '0;
    end else if (cmd.srch_step) begin
      scan_d_r <= scan_d_r + ADDR_W'(1);
    end
  end

  // Output fields are narrowed from the internal count and distance.
  always_comb begin
    cnt_wide  = (CNT_W + bss_pkg::COUNT_W)'(count_nxt);
    dist_wide = (ADDR_W + bss_pkg::DIST_W)'(scan_d_r);
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r   <= cmd.out_status;
      out_popped_r   <= cmd.out_sel_pop ? rdata_r : '0;
      out_distance_r <= cmd.out_sel_dist ? dist_wide[bss_pkg::DIST_W-1:0] : '0;
      out_count_r    <= cnt_wide[bss_pkg::COUNT_W-1:0];
      out_is_empty_r <= (count_nxt == '0);
      out_is_full_r  <= (CMP_W'(count_nxt) >= eff_cap);
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_status   = out_status_r;
  assign out_popped   = out_popped_r;
  assign out_distance = out_distance_r;
  assign out_count    = out_count_r;
  assign out_is_empty = out_is_empty_r;
  assign out_is_full  = out_is_full_r;

endmodule

@@ hdl/bss_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bounded stack with search: controller
// Decodes each input beat into datapath commands and sequences the pop
// read and the top-down search scan.
// ----------------------------------------------------------------------------
module bss_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic [bss_pkg::KIND_W-1:0]    in_kind,
  output logic                          in_tready,
  input  bss_pkg::dp_status_t           status,
  output bss_pkg::ctl_cmd_t             cmd,
  output bss_pkg::state_t               state
);

  bss_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bss_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    cmd            = '0;
    cmd.out_status = bss_pkg::ST_OK;
    unique case (state_r)
      bss_pkg::S_IDLE: begin
        // Only take a beat when the output register can hold its result.
        in_tready = status.out_free;
        if (in_tvalid && status.out_free) begin
          cmd.accept = 1'b1;
          unique case (bss_pkg::kind_t'(in_kind))
            bss_pkg::KIND_PUSH: begin
              cmd.out_load = 1'b1;
              if (status.full) begin
                cmd.out_status = bss_pkg::ST_FULL;
              end else begin
                cmd.push = 1'b1;
              end
            end
            bss_pkg::KIND_POP: begin
              if (status.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = bss_pkg::ST_EMPTY;
              end else begin
                cmd.pop   = 1'b1;
                state_nxt = bss_pkg::S_POP;
              end
            end
            bss_pkg::KIND_SEARCH: begin
              if (status.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = bss_pkg::ST_EMPTY;
              end else begin
                cmd.srch_start = 1'b1;
                state_nxt      = bss_pkg::S_SRCH;
              end
            end
            default: begin
              // Unused operation code: report ok and change nothing.
              cmd.out_load = 1'b1;
            end
          endcase
        end
      end
      bss_pkg::S_POP: begin
        // The popped word has arrived from the memory read port.
        cmd.out_load    = 1'b1;
        cmd.out_sel_pop = 1'b1;
        state_nxt       = bss_pkg::S_IDLE;
      end
      bss_pkg::S_SRCH: begin
        if (status.hit) begin
          cmd.out_load     = 1'b1;
          cmd.out_sel_dist = 1'b1;
          state_nxt        = bss_pkg::S_IDLE;
        end else if (status.scan_last) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = bss_pkg::ST_NOT_FOUND;
          state_nxt      = bss_pkg::S_IDLE;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      default: begin
        state_nxt = bss_pkg::S_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule

@@ hdl/bounded_stack_with_search.sv @@
// ----------------------------------------------------------------------------
// Bounded stack with search: top level
// LIFO of 32-bit words with push, pop and top-down search operations.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one operation per beat: the kind in in_tuser
//   (push, pop, search) and the word in in_tdata. Every accepted beat gives
//   exactly one result beat on the output stream, in order.
//   A push, a refused operation or an unused kind is done when accepted, so
//   these stream at one beat per cycle while the receiver keeps up; the
//   result appears the cycle after. A pop reads the top word through the
//   memory read port, then the result is registered. A search reads one word
//   per cycle from the top down through the single read port, to the first hit or the bottom word.
//   No new beat is taken while a pop or a search is in progress.
//   The output register decouples the sides: a new beat is taken while a
//   result waits, as long as that result is taken in the same cycle or the
//   register is empty. A stalled receiver holds the result and stops intake.
//   Reset empties the stack and sets the capacity to 256; the word memory
//   is not cleared, since a word is never used before it has been written.
//   The capacity register is written through cfg_wr_en/cfg_wr_data; the user
//   must do so only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module bounded_stack_with_search #(
  parameter int DEPTH = bss_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration: capacity.
  input  logic                               cfg_wr_en,
  input  logic [bss_pkg::CAP_W-1:0]          cfg_wr_data,
  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bss_pkg::WORD_W-1:0]         in_tdata,   // [31:0] value
  input  logic [bss_pkg::KIND_W-1:0]         in_tuser,   // [1:0] kind
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] popped, [39:32] distance, [48:40] count, [49] is_empty,
  // [50] is_full, [55:51] zero
  output logic [bss_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [bss_pkg::STATUS_W-1:0]       out_tuser   // [1:0] status
);

  bss_pkg::ctl_cmd_t   cmd;
  bss_pkg::dp_status_t dp_status;
  bss_pkg::state_t     state;

  logic [bss_pkg::WORD_W-1:0]  popped;
  logic [bss_pkg::DIST_W-1:0]  distance;
  logic [bss_pkg::COUNT_W-1:0] count;
  logic                        is_empty;
  logic                        is_full;

  bss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .status    (dp_status),
    .cmd       (cmd),
    .state     (state)
  );

  bss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_word      (in_tdata),
    .cmd          (cmd),
    .status       (dp_status),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_status   (out_tuser),
    .out_popped   (popped),
    .out_distance (distance),
    .out_count    (count),
    .out_is_empty (is_empty),
    .out_is_full  (is_full)
  );

  // Pack the result fields, highest field first.
  assign out_tdata = {5'b0, is_full, is_empty, count, distance, popped};

  // Intake only happens while the output register is free.
  a_intake_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("input beat taken while the output register is blocked");

  // Intake is closed while a pop or a search is in progress.
  a_busy_no_intake: assert property (@(posedge clk) disable iff (!rst_n)
    (state != bss_pkg::S_IDLE) |-> !in_tready)
    else $error("input ready while an operation is in progress");

  // A refused push is only reported by a full stack.
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == bss_pkg::ST_FULL)) |-> is_full)
    else $error("full status without the full flag");

  // An empty status always comes with an empty stack and zero count.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == bss_pkg::ST_EMPTY)) |-> (is_empty && (count == '0)))
    else $error("empty status with words still held");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Bounded stack with search: testbench
// Drives push, pop, search and unused operations into the stack and checks
// every result beat against a shadow stack kept inside the testbench. The
// directed tests cover the refused operations, the capacity corners and the
// full depth. The random traffic runs under several capacities, with random
// gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 20;
  localparam int SHADOW_DEPTH = bss_pkg::DEPTH_DEF;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam logic [bss_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Expected contents of one result beat.
  typedef struct {
    bss_pkg::status_t                status;
    logic [bss_pkg::WORD_W-1:0]      popped;
    logic [bss_pkg::DIST_W-1:0]      distance;
    logic [bss_pkg::COUNT_W-1:0]     count;
    logic                            is_empty;
    logic                            is_full;
  } stack_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [bss_pkg::CAP_W-1:0] cfg_wr_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [bss_pkg::WORD_W-1:0] in_tdata = '0;     // [31:0] value
  logic [bss_pkg::KIND_W-1:0] in_tuser = '0;     // [1:0] kind
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [31:0] popped, [39:32] distance, [48:40] count, [49] is_empty,
  // [50] is_full, [55:51] zero
  logic [bss_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [bss_pkg::STATUS_W-1:0] out_tuser;       // [1:0] status

  // Shadow copy of the stack and its capacity register.
  logic [bss_pkg::WORD_W-1:0] shadow_words [SHADOW_DEPTH];
  int                         shadow_depth = 0;
  logic [bss_pkg::CAP_W-1:0]  shadow_cap = bss_pkg::CAP_RESET;

  stack_reply_t replies_due [$];
  int  mismatches = 0;
  int  cycle_count = 0;
  bit  tx_gaps_on = 1'b1;
  bit  rx_stalls_on = 1'b1;
  int  rx_hold_cycles = 0;

  bounded_stack_with_search uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Capacity in effect: the register value, clipped to the memory depth.
  function automatic int usable_capacity();
    return (int'(shadow_cap) > SHADOW_DEPTH) ? SHADOW_DEPTH : int'(shadow_cap);
  endfunction

  // Apply one operation to the shadow stack and return the result it gives.
  function automatic stack_reply_t predict_stack_op(
      input logic [bss_pkg::KIND_W-1:0] kind,
      input logic [bss_pkg::WORD_W-1:0] value);
    stack_reply_t r;
    r.status = bss_pkg::ST_OK;
    r.popped = '0;
    r.distance = '0;
    case (kind)
      bss_pkg::KIND_PUSH: begin
        if (shadow_depth >= usable_capacity()) begin
          r.status = bss_pkg::ST_FULL;
        end else begin
          shadow_words[shadow_depth] = value;
          shadow_depth++;
        end
      end
      bss_pkg::KIND_POP: begin
        if (shadow_depth == 0) begin
          r.status = bss_pkg::ST_EMPTY;
        end else begin
          shadow_depth--;
          r.popped = shadow_words[shadow_depth];
        end
      end
      bss_pkg::KIND_SEARCH: begin
        if (shadow_depth == 0) begin
          r.status = bss_pkg::ST_EMPTY;
        end else begin
          // Scan from the top down; the first match wins.
          r.status = bss_pkg::ST_NOT_FOUND;
          for (int d = 0; d < shadow_depth; d++) begin
            if (shadow_words[shadow_depth - 1 - d] == value) begin
              r.status = bss_pkg::ST_OK;
              r.distance = 8'(d);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.count = 9'(shadow_depth);
    r.is_empty = (shadow_depth == 0);
    r.is_full = (shadow_depth >= usable_capacity());
    return r;
  endfunction

  // Idle lengths: mostly short, now and then long.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Words to push: a small pool for duplicates, the extremes, or anything.
  function automatic logic [bss_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0, 1: return 32'($urandom_range(0, 5));
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Words to look for: mostly ones held somewhere in the stack.
  function automatic logic [bss_pkg::WORD_W-1:0] search_word();
    if (shadow_depth > 0 && $urandom_range(0, 9) < 7)
      return shadow_words[$urandom_range(0, shadow_depth - 1)];
    return pick_word();
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  // Offer one beat and record its expected result once it is taken.
  // The valid stays high afterwards so that back-to-back beats need no toggle.
  task automatic send_op(input logic [bss_pkg::KIND_W-1:0] kind,
                         input logic [bss_pkg::WORD_W-1:0] value);
    int gap;
    gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    replies_due.push_back(predict_stack_op(kind, value));
  endtask

  // Stop offering beats and wait until every result has come back.
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // The capacity is only written while the block is idle.
  task automatic set_capacity(input logic [bss_pkg::CAP_W-1:0] cap);
    drain_replies();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_cap = cap;
  endtask

  task automatic empty_stack();
    while (shadow_depth > 0) send_op(bss_pkg::KIND_POP, $urandom());
  endtask

  // Refused operations, field extremes and the capacity corners.
  task automatic test_directed();
    set_capacity(9'd3);
    send_op(bss_pkg::KIND_POP, 32'h0000_0000);
    send_op(bss_pkg::KIND_SEARCH, 32'hFFFF_FFFF);
    send_op(KIND_UNUSED, 32'hFFFF_FFFF);
    send_op(bss_pkg::KIND_PUSH, 32'h8000_0000);
    send_op(bss_pkg::KIND_PUSH, 32'h7FFF_FFFF);
    send_op(bss_pkg::KIND_PUSH, 32'hFFFF_FFFF);
    send_op(bss_pkg::KIND_PUSH, 32'h0000_0000);
    send_op(bss_pkg::KIND_SEARCH, 32'h8000_0000);
    send_op(bss_pkg::KIND_SEARCH, 32'hFFFF_FFFF);
    send_op(bss_pkg::KIND_SEARCH, 32'h0000_0000);
    send_op(KIND_UNUSED, 32'h0000_0000);
    send_op(bss_pkg::KIND_POP, 32'hFFFF_FFFF);
    // Capacity now below the count: the stack reads as full.
    set_capacity(9'd1);
    send_op(bss_pkg::KIND_PUSH, 32'h1234_5678);
    send_op(bss_pkg::KIND_SEARCH, 32'h7FFF_FFFF);
    send_op(bss_pkg::KIND_POP, 32'h0000_0000);
    send_op(bss_pkg::KIND_POP, 32'h0000_0000);
    send_op(bss_pkg::KIND_POP, 32'h0000_0000);
    // Zero capacity refuses every push.
    set_capacity(9'd0);
    send_op(bss_pkg::KIND_PUSH, 32'h0000_0001);
    send_op(bss_pkg::KIND_SEARCH, 32'h0000_0001);
    send_op(bss_pkg::KIND_POP, 32'h0000_0001);
    // Capacity above the depth; duplicates resolve to the one nearest the top.
    set_capacity(9'd511);
    send_op(bss_pkg::KIND_PUSH, 32'h0000_0000);
    send_op(bss_pkg::KIND_PUSH, 32'h1234_5678);
    send_op(bss_pkg::KIND_PUSH, 32'h0000_0000);
    send_op(bss_pkg::KIND_SEARCH, 32'h0000_0000);
  endtask

  // Fill all of the memory, search its full length, then empty it.
  task automatic test_full_depth();
    set_capacity(9'd256);
    empty_stack();
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    // Even words only, so that an odd word is sure to miss.
    for (int i = 0; i < SHADOW_DEPTH; i++)
      send_op(bss_pkg::KIND_PUSH, $urandom() & 32'hFFFF_FFFE);
    send_op(bss_pkg::KIND_PUSH, 32'h5555_AAAA);
    send_op(bss_pkg::KIND_SEARCH, shadow_words[0]);
    send_op(bss_pkg::KIND_SEARCH, 32'hDEAD_BEEF);
    send_op(bss_pkg::KIND_SEARCH, shadow_words[SHADOW_DEPTH - 1]);
    set_capacity(9'd300);
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    send_op(bss_pkg::KIND_PUSH, 32'h0000_0002);
    empty_stack();
  endtask

  // The receiver holds off for long stretches while beats keep coming.
  task automatic test_backpressure();
    set_capacity(9'd32);
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    rx_hold_cycles = 80;
    for (int i = 0; i < 24; i++) send_op(bss_pkg::KIND_PUSH, pick_word());
    rx_hold_cycles = 50;
    for (int i = 0; i < 8; i++) begin
      send_op(bss_pkg::KIND_SEARCH, search_word());
      send_op(bss_pkg::KIND_POP, $urandom());
    end
    drain_replies();
  endtask

  // Random walk that swings between filling and draining the stack.
  task automatic run_traffic_phase(input logic [bss_pkg::CAP_W-1:0] cap, input int n_ops);
    int sent;
    int r;
    bit filling;
    logic [bss_pkg::KIND_W-1:0] kind;
    set_capacity(cap);
    tx_gaps_on = ($urandom_range(0, 3) != 0);
    rx_stalls_on = ($urandom_range(0, 3) != 0);
    filling = 1'b1;
    sent = 0;
    while (sent < n_ops) begin
      if (shadow_depth == 0) filling = 1'b1;
      else if (shadow_depth >= usable_capacity()) filling = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 3) kind = KIND_UNUSED;
      else if (r < 25) kind = bss_pkg::KIND_SEARCH;
      else if (r < (filling ? 85 : 40)) kind = bss_pkg::KIND_PUSH;
      else kind = bss_pkg::KIND_POP;
      send_op(kind, (kind == bss_pkg::KIND_SEARCH) ? search_word() : pick_word());
      if (kind != KIND_UNUSED) sent++;
    end
  endtask

  task automatic test_random_traffic();
    logic [bss_pkg::CAP_W-1:0] caps [$];
    caps = '{9'd2, 9'd1, 9'd7, 9'd0, 9'd16, 9'd511, 9'd5, 9'd64, 9'd3, 9'd256, 9'd40};
    foreach (caps[i]) run_traffic_phase(caps[i], 16);
    run_traffic_phase(9'($urandom_range(0, 511)), 16);
    run_traffic_phase(9'($urandom_range(1, 12)), 16);
  endtask

  // Receiver pacing: random stalls, plus long holds on request.
  initial begin : rx_pacing
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
        n = pick_gap();
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin : result_check
    stack_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        $error("result beat with no operation pending");
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        check_field("status", 32'(want.status), 32'(out_tuser));
        check_field("popped", want.popped, out_tdata[31:0]);
        check_field("distance", 32'(want.distance), 32'(out_tdata[39:32]));
        check_field("count", 32'(want.count), 32'(out_tdata[48:40]));
        check_field("is_empty", 32'(want.is_empty), 32'(out_tdata[49]));
        check_field("is_full", 32'(want.is_full), 32'(out_tdata[50]));
        check_field("padding", 32'h0, 32'(out_tdata[55:51]));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_depth();
    test_backpressure();
    test_random_traffic();
    drain_replies();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
